FILE: sv/frg_pkg.sv
`timescale 1ns / 1ps

package frg_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DATA_WIDTH);

   localparam logic [CNT_W-1:0]      CNT_LAST = CNT_W'(DATA_WIDTH - 1);
   localparam logic [DATA_WIDTH-1:0] MIN_VAL  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] NEG_ONE  = {DATA_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_ZERO_DEN = 2'd1,
      ERR_OVERFLOW = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      SEL_EUCLID = 2'd0,
      SEL_NUM    = 2'd1,
      SEL_DEN    = 2'd2
   } sel_type;

   typedef struct packed {
      logic    load;
      logic    div_start;
      sel_type div_sel;
      logic    div_step;
      logic    euclid_upd;
      logic    store_num;
      logic    store_den;
      logic    set_err;
      err_type err;
      logic    publish;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic b_zero;
      logic ovf;
   } sts_type;

endpackage

FILE: sv/fraction_reduce_gcd.sv
`timescale 1ns / 1ps
// fraction reduction by euclid's algorithm with truncating remainder
// req channel: req_num_in / req_den_in, signed two's complement, valid/ready
// rsp channel: rsp_num_out / rsp_den_out / rsp_err_code, valid/ready
// err code 0 ok, 1 zero denominator, 2 quotient overflow; on error both
// parts are zero
// one item at a time: a single restoring divider, one quotient bit per cycle,
// is shared by every remainder step and by the two final divisions
// an item runs its remainder steps, then divides numerator and denominator
// by the last nonzero remainder; a zero denominator ends the item before any
// division, a quotient overflow ends it after the last remainder step
// the next beat can be taken in the same cycle that rsp_valid rises
// req_ready is high only while no item is being worked on
// the result sits in an output register, so the next beat is taken while it
// waits; if rsp_ready stays low the finished item waits for the register
// reset is synchronous, active high, and drops rsp_valid and any item in work
module fraction_reduce_gcd (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [frg_pkg::DATA_WIDTH-1:0] req_num_in,
   input  logic [frg_pkg::DATA_WIDTH-1:0] req_den_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [frg_pkg::DATA_WIDTH-1:0] rsp_num_out,
   output logic [frg_pkg::DATA_WIDTH-1:0] rsp_den_out,
   output logic [1:0]                     rsp_err_code
);

   frg_pkg::cmd_type cmd;
   frg_pkg::sts_type sts;

   frg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   frg_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_num_in   (req_num_in),
      .req_den_in   (req_den_in),
      .rsp_num_out  (rsp_num_out),
      .rsp_den_out  (rsp_den_out),
      .rsp_err_code (rsp_err_code)
   );

endmodule

FILE: sv/frg_dpath.sv
`timescale 1ns / 1ps

module frg_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  frg_pkg::cmd_type                   cmd,
   output frg_pkg::sts_type                   sts,
   input  logic [frg_pkg::DATA_WIDTH-1:0]     req_num_in,
   input  logic [frg_pkg::DATA_WIDTH-1:0]     req_den_in,
   output logic [frg_pkg::DATA_WIDTH-1:0]     rsp_num_out,
   output logic [frg_pkg::DATA_WIDTH-1:0]     rsp_den_out,
   output logic [1:0]                         rsp_err_code
);

   localparam int W = frg_pkg::DATA_WIDTH;

   logic [W-1:0]     num_ff, den_ff, a_ff, b_ff;
   logic [W-1:0]     quo_ff, rem_ff, dv_ff;
   logic             rneg_ff, qneg_ff;
   logic [W-1:0]     wnum_ff, wden_ff;
   frg_pkg::err_type werr_ff;
   logic [W-1:0]     onum_ff, oden_ff;
   frg_pkg::err_type oerr_ff;

   logic [W-1:0]     dd, dv, dd_mag, dv_mag;
   logic [W:0]       shifted, diff;
   logic [W-1:0]     rem_in, quo_in, rem_s, quo_s;

   // operand select for the shared divider
   always_comb begin
      case (cmd.div_sel)
         frg_pkg::SEL_EUCLID: begin
            dd = a_ff;
            dv = b_ff;
         end
         frg_pkg::SEL_NUM: begin
            dd = num_ff;
            dv = a_ff;
         end
         frg_pkg::SEL_DEN: begin
            dd = den_ff;
            dv = a_ff;
         end
         default: begin
            dd = a_ff;
            dv = b_ff;
         end
      endcase
      dd_mag = dd[W-1] ? (~dd + W'(1)) : dd;
      dv_mag = dv[W-1] ? (~dv + W'(1)) : dv;
   end

   // one restoring step per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, dv_ff};
      if (!diff[W]) begin
         rem_in = diff[W-1:0];
         quo_in = {quo_ff[W-2:0], 1'b1};
      end else begin
         rem_in = shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], 1'b0};
      end
      // remainder follows the dividend sign, quotient the sign product
      rem_s = rneg_ff ? (~rem_ff + W'(1)) : rem_ff;
      quo_s = qneg_ff ? (~quo_ff + W'(1)) : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         num_ff <= req_num_in;
         den_ff <= req_den_in;
         a_ff   <= req_num_in;
         b_ff   <= req_den_in;
      end else if (cmd.euclid_upd) begin
         a_ff <= b_ff;
         b_ff <= rem_s;
      end

      if (cmd.div_start) begin
         quo_ff  <= dd_mag;
         dv_ff   <= dv_mag;
         rem_ff  <= '0;
         rneg_ff <= dd[W-1];
         qneg_ff <= dd[W-1] ^ dv[W-1];
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end

      if (cmd.store_num) wnum_ff <= quo_s;
      if (cmd.store_den) wden_ff <= quo_s;

      if (cmd.publish) begin
         onum_ff <= (werr_ff == frg_pkg::ERR_NONE) ? wnum_ff : '0;
         oden_ff <= (werr_ff == frg_pkg::ERR_NONE) ? wden_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         werr_ff <= frg_pkg::ERR_NONE;
         oerr_ff <= frg_pkg::ERR_NONE;
      end else begin
         if (cmd.load) begin
            werr_ff <= frg_pkg::ERR_NONE;
         end else if (cmd.set_err) begin
            werr_ff <= cmd.err;
         end
         if (cmd.publish) oerr_ff <= werr_ff;
      end
   end

   always_comb begin
      sts.den_zero = (den_ff == '0);
      sts.b_zero   = (b_ff == '0);
      sts.ovf      = (a_ff == frg_pkg::NEG_ONE) &&
                     ((num_ff == frg_pkg::MIN_VAL) || (den_ff == frg_pkg::MIN_VAL));
   end

   assign rsp_num_out  = onum_ff;
   assign rsp_den_out  = oden_ff;
   assign rsp_err_code = oerr_ff;

   // a remainder step never runs against a zero divisor
   a_euclid_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.euclid_upd |-> (b_ff != '0))
      else $error("euclid update with zero divisor");

   // a published error result carries zero fields
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.publish && (werr_ff != frg_pkg::ERR_NONE) |=>
         (onum_ff == '0) && (oden_ff == '0))
      else $error("error result with nonzero fields");

endmodule

FILE: sv/frg_ctrl.sv
`timescale 1ns / 1ps

module frg_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output frg_pkg::cmd_type cmd,
   input  frg_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_POST,
      S_TEST,
      S_DONE
   } state_type;

   state_type                   state_ff, state_in;
   frg_pkg::sel_type            phase_ff, phase_in;
   logic [frg_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.div_sel  = phase_ff;
      cmd.err      = frg_pkg::ERR_NONE;
      state_in     = state_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.den_zero) begin
               cmd.set_err = 1'b1;
               cmd.err     = frg_pkg::ERR_ZERO_DEN;
               state_in    = S_DONE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = frg_pkg::SEL_EUCLID;
               phase_in      = frg_pkg::SEL_EUCLID;
               cnt_in        = '0;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + frg_pkg::CNT_W'(1);
            if (cnt_ff == frg_pkg::CNT_LAST) state_in = S_POST;
         end
         S_POST: begin
            case (phase_ff)
               frg_pkg::SEL_EUCLID: begin
                  cmd.euclid_upd = 1'b1;
                  state_in       = S_TEST;
               end
               frg_pkg::SEL_NUM: begin
                  cmd.store_num = 1'b1;
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = frg_pkg::SEL_DEN;
                  phase_in      = frg_pkg::SEL_DEN;
                  cnt_in        = '0;
                  state_in      = S_DIV;
               end
               default: begin
                  cmd.store_den = 1'b1;
                  state_in      = S_DONE;
               end
            endcase
         end
         S_TEST: begin
            cmd.div_start = 1'b1;
            cnt_in        = '0;
            state_in      = S_DIV;
            if (!sts.b_zero) begin
               cmd.div_sel = frg_pkg::SEL_EUCLID;
            end else if (sts.ovf) begin
               cmd.div_start = 1'b0;
               cmd.set_err   = 1'b1;
               cmd.err       = frg_pkg::ERR_OVERFLOW;
               state_in      = S_DONE;
            end else begin
               cmd.div_sel = frg_pkg::SEL_NUM;
               phase_in    = frg_pkg::SEL_NUM;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= frg_pkg::SEL_EUCLID;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) && (cnt_ff != frg_pkg::CNT_LAST) |=> (state_ff == S_DIV))
      else $error("division left early");

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("published result not presented");

endmodule
